FILE: rtl/fohp_pkg.sv
// Shared types and constants for the first-order highpass filter.
package fohp_pkg;

	localparam int COEF_BITS    = 24;
	localparam int CHAN_BITS    = 4;
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic {
		CMD_FILTER = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COEF_A0 = 2'd0,
		REG_COEF_A1 = 2'd1,
		REG_COEF_B1 = 2'd2
	} cfg_reg_t;

endpackage

FILE: rtl/fohp_if.sv
// Handshake interfaces for the sample, result and configuration channels.
interface fohp_sample_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic [fohp_pkg::CHAN_BITS-1:0]      channel;
	logic signed [SAMPLE_BITS-1:0]       sample_in;

	modport source (output valid, command, channel, sample_in, input ready);
	modport sink   (input valid, command, channel, sample_in, output ready);
endinterface

interface fohp_result_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                                valid;
	logic                                ready;
	logic [fohp_pkg::CHAN_BITS-1:0]      channel_out;
	logic signed [SAMPLE_BITS-1:0]       sample_out;
	logic                                saturated;

	modport source (output valid, channel_out, sample_out, saturated, input ready);
	modport sink   (input valid, channel_out, sample_out, saturated, output ready);
endinterface

interface fohp_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [fohp_pkg::CFG_IDX_BITS-1:0]   index;
	logic [fohp_pkg::COEF_BITS-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/first_order_highpass_iir.sv
// Multichannel first-order highpass IIR: y = a0*x + a1*x_prev - b1*y_prev.
//
// Channels: samples (sink) carries command, channel and sample_in; results
// (source) carries channel_out, sample_out and saturated; cfg (sink) writes
// coef_a0/a1/b1 by index and is always ready. Coefficients are Q2.22 by default.
// A clear command zeroes every channel's history and produces no result beat.
// Path: an accepted sample is held in the input stage, then in the result register.
// Throughput: one sample per cycle, even on one channel, unless results stall.
// The per-channel history sits in two small memories read when a sample
// is accepted; a write from the sample one stage ahead is forwarded.
// Three products, one wide sum, round and saturate fit between the input
// stage and the result register, so the feedback loop needs no extra register.
// Reset: coefficients go to zero, all history reads as zero (valid bits
// cleared), no result is pending.
// Stall: the result register holds while results.ready is low; one more
// sample is taken into the input stage, then samples.ready drops.
module first_order_highpass_iir #(
	parameter int NUM_CHANNELS   = 16,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fohp_cfg_if.sink             cfg,
	fohp_sample_if.sink          samples,
	fohp_result_if.source        results
);

	localparam int CB    = fohp_pkg::COEF_BITS;
	localparam int CHB   = fohp_pkg::CHAN_BITS;
	localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PW    = SAMPLE_BITS + CB;
	localparam int ACC_W = PW + 2;

	localparam logic signed [ACC_W-1:0] SMAX =
		{{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMIN =
		{{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] HALF =
		ACC_W'(1) << (COEF_FRAC_BITS - 1);

	// coefficients
	logic signed [CB-1:0] coef_a0_q, coef_a1_q, coef_b1_q;

	// history storage
	logic signed [SAMPLE_BITS-1:0] mem_x [NUM_CHANNELS];
	logic signed [SAMPLE_BITS-1:0] mem_y [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]       hist_valid_q;

	// input stage
	logic                          valid_s1;
	logic [AW-1:0]                 addr_s1;
	logic [CHB-1:0]                chan_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic signed [SAMPLE_BITS-1:0] hx_s1, hy_s1;
	logic                          hval_s1;
	logic                          fwd_s1;
	logic signed [SAMPLE_BITS-1:0] fx_s1, fy_s1;

	// result register
	logic                          out_valid_q;
	logic [CHB-1:0]                chan_out_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          sat_out_q;

	logic                          accept, is_clear, in_range, load_s1;
	logic                          advance, wr_en, fwd;
	logic [AW-1:0]                 addr_in;
	logic signed [SAMPLE_BITS-1:0] hist_x, hist_y;
	logic signed [PW-1:0]          p_a0, p_a1, p_b1;
	logic signed [ACC_W-1:0]       acc, rnd, q_full;
	logic                          sat_hi, sat_lo;
	logic signed [SAMPLE_BITS-1:0] y_new;

	assign accept   = samples.valid && samples.ready;
	assign is_clear = (samples.command == fohp_pkg::CMD_CLEAR);
	assign in_range = (32'(samples.channel) < 32'(NUM_CHANNELS));
	assign addr_in  = AW'(samples.channel);
	assign load_s1  = accept && !is_clear && in_range;

	assign advance       = !out_valid_q || results.ready;
	assign samples.ready = !valid_s1 || advance;
	assign wr_en         = valid_s1 && advance;
	// the stage ahead writes this channel at the same edge: take its values
	assign fwd           = wr_en && (addr_s1 == addr_in);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a0_q <= '0;
			coef_a1_q <= '0;
			coef_b1_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				fohp_pkg::REG_COEF_A0: coef_a0_q <= cfg.data;
				fohp_pkg::REG_COEF_A1: coef_a1_q <= cfg.data;
				fohp_pkg::REG_COEF_B1: coef_b1_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// clear wins over a same-edge write from the older sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '0;
		end else if (accept && is_clear) begin
			hist_valid_q <= '0;
		end else if (wr_en) begin
			hist_valid_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[addr_s1] <= x_s1;
			mem_y[addr_s1] <= y_new;
		end
		if (load_s1) begin
			hx_s1 <= mem_x[addr_in];
			hy_s1 <= mem_y[addr_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			addr_s1 <= addr_in;
			chan_s1 <= samples.channel;
			x_s1    <= samples.sample_in;
			hval_s1 <= hist_valid_q[addr_in];
			fwd_s1  <= fwd;
			fx_s1   <= x_s1;
			fy_s1   <= y_new;
		end
	end

	assign hist_x = fwd_s1 ? fx_s1 : (hval_s1 ? hx_s1 : '0);
	assign hist_y = fwd_s1 ? fy_s1 : (hval_s1 ? hy_s1 : '0);

	assign p_a0 = PW'(x_s1) * PW'(coef_a0_q);
	assign p_a1 = PW'(hist_x) * PW'(coef_a1_q);
	assign p_b1 = PW'(hist_y) * PW'(coef_b1_q);

	assign acc = {{2{p_a0[PW-1]}}, p_a0} + {{2{p_a1[PW-1]}}, p_a1}
		- {{2{p_b1[PW-1]}}, p_b1};
	// round half up, then floor by arithmetic shift
	assign rnd    = acc + HALF;
	assign q_full = rnd >>> COEF_FRAC_BITS;
	assign sat_hi = (q_full > SMAX);
	assign sat_lo = (q_full < SMIN);

	always_comb begin
		if (sat_hi) begin
			y_new = SMAX[SAMPLE_BITS-1:0];
		end else if (sat_lo) begin
			y_new = SMIN[SAMPLE_BITS-1:0];
		end else begin
			y_new = q_full[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			chan_out_q   <= chan_s1;
			sample_out_q <= y_new;
			sat_out_q    <= sat_hi || sat_lo;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.channel_out = chan_out_q;
	assign results.sample_out  = sample_out_q;
	assign results.saturated   = sat_out_q;

endmodule

FILE: rtl/fohp_checker.sv
// Port-level checks for the highpass filter, bound to the top level.
module fohp_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_valid,
	input logic                            s_ready,
	input logic                            s_command,
	input logic                            r_valid,
	input logic                            r_ready,
	input logic [fohp_pkg::CHAN_BITS-1:0]  r_channel,
	input logic [SAMPLE_BITS-1:0]          r_sample,
	input logic                            r_saturated
);

	localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_channel)
			&& $stable(r_sample) && $stable(r_saturated))
		else $error("result beat changed while stalled");

	// input backpressure only comes from a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_ready |-> r_valid && !r_ready)
		else $error("input stalled without output backpressure");

	// a fresh result follows a filter beat via input and result regs
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |->
			$past(s_valid && s_ready && (s_command == fohp_pkg::CMD_FILTER), 2))
		else $error("result without a matching filter beat");

	// a clipped result sits at a rail
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_saturated |-> (r_sample == S_MAX) || (r_sample == S_MIN))
		else $error("saturated flag with an unclipped value");

endmodule

bind first_order_highpass_iir fohp_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_fohp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.s_valid     (samples.valid),
	.s_ready     (samples.ready),
	.s_command   (samples.command),
	.r_valid     (results.valid),
	.r_ready     (results.ready),
	.r_channel   (results.channel_out),
	.r_sample    (results.sample_out),
	.r_saturated (results.saturated)
);
